@@ rtl/core/mmsn_pkg.sv @@
package mmsn_pkg;

  // Fixed port widths
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 15;

  // Parameter defaults
  localparam int CHANNELS_DEF    = 6;
  localparam int SAMPLE_BITS_DEF = 10;

  // level = (x - lo) * (PERCENT_FULL << FRAC_BITS) / (hi - lo)
  localparam int PERCENT_FULL = 100;
  localparam int PERCENT_W    = 7;
  localparam int FRAC_BITS    = 8;
  localparam int QUOT_BITS    = LEVEL_W;
  localparam int CNT_W        = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic scale;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/core/mmsn_ctrl.sv @@
module mmsn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mmsn_pkg::sts_t sts,
  output mmsn_pkg::cmd_t cmd
);

  mmsn_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmsn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      mmsn_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = mmsn_pkg::ST_UPDATE;
        end
      end
      mmsn_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = mmsn_pkg::ST_SCALE;
      end
      mmsn_pkg::ST_SCALE: begin
        // flat or foreign channel: level already cleared
        if (sts.skip_div) begin
          state_next = mmsn_pkg::ST_FINISH;
        end else begin
          cmd.scale  = 1'b1;
          state_next = mmsn_pkg::ST_DIVIDE;
        end
      end
      mmsn_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = mmsn_pkg::ST_FINISH;
        end
      end
      mmsn_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = mmsn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mmsn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/mmsn_datapath.sv @@
module mmsn_datapath #(
  parameter int CHANNELS    = mmsn_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = mmsn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mmsn_pkg::CH_W-1:0]     channel,
  input  logic [mmsn_pkg::SAMPLE_W-1:0] sample,
  input  mmsn_pkg::cmd_t                cmd,
  output mmsn_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mmsn_pkg::CH_W-1:0]     channel_out,
  output logic [mmsn_pkg::LEVEL_W-1:0]  level_q8,
  output logic                          flat
);

  localparam int MW     = SAMPLE_BITS;
  localparam int IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CWW    = mmsn_pkg::CH_W + IW;
  localparam int PW     = MW + mmsn_pkg::PERCENT_W;
  localparam int SH     = mmsn_pkg::QUOT_BITS - mmsn_pkg::FRAC_BITS;
  localparam int QB     = mmsn_pkg::QUOT_BITS;
  localparam logic [mmsn_pkg::CNT_W-1:0] CNT_LAST = mmsn_pkg::CNT_W'(QB - 1);

  // Captured beat
  logic [mmsn_pkg::CH_W-1:0] ch;
  logic [MW-1:0]             x;

  // Per-channel marks
  logic [MW-1:0] low_mark  [CHANNELS];
  logic [MW-1:0] high_mark [CHANNELS];

  // Division state
  logic [MW-1:0]                diff;
  logic [MW-1:0]                span;
  logic                         skip;
  logic                         flat_r;
  logic [MW-1:0]                rem;
  logic [QB-1:0]                dividend_lo;
  logic [QB-1:0]                quot;
  logic [mmsn_pkg::CNT_W-1:0]   cnt;

  logic [MW+mmsn_pkg::SAMPLE_W-1:0] sample_wide;
  logic [CWW-1:0]                   ch_wide;
  logic [IW-1:0]                    idx;
  logic                             in_range;
  logic [MW-1:0]                    lo_cur, hi_cur, lo_new, hi_new;
  logic [PW-1:0]                    prod;
  logic [MW:0]                      trial;
  logic                             qbit;

  // Keep only the low SAMPLE_BITS bits of the sample
  assign sample_wide = (MW + mmsn_pkg::SAMPLE_W)'(sample);

  assign ch_wide  = CWW'(ch);
  assign idx      = ch_wide[IW-1:0];
  assign in_range = ch_wide < CWW'(CHANNELS);

  assign lo_cur = low_mark[idx];
  assign hi_cur = high_mark[idx];
  assign lo_new = (x < lo_cur) ? x : lo_cur;
  assign hi_new = (x > hi_cur) ? x : hi_cur;

  assign prod  = PW'(diff) * PW'(mmsn_pkg::PERCENT_FULL);
  assign trial = {rem, dividend_lo[QB-1]};
  assign qbit  = trial >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch <= channel;
      x  <= sample_wide[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        low_mark[i]  <= '1;
        high_mark[i] <= '0;
      end
    end else if (cmd.update && in_range) begin
      low_mark[idx]  <= lo_new;
      high_mark[idx] <= hi_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      diff   <= x - lo_new;
      span   <= hi_new - lo_new;
      flat_r <= in_range && (hi_new == lo_new);
      skip   <= !in_range || (hi_new == lo_new);
      quot   <= '0;
    end else if (cmd.scale) begin
      // top bits of the scaled numerator are below span by construction
      rem         <= prod[PW-1:SH];
      dividend_lo <= QB'({prod[SH-1:0], mmsn_pkg::FRAC_BITS'(0)});
      cnt         <= '0;
    end else if (cmd.div_step) begin
      rem         <= qbit ? MW'(trial - {1'b0, span}) : trial[MW-1:0];
      dividend_lo <= {dividend_lo[QB-2:0], 1'b0};
      quot        <= {quot[QB-2:0], qbit};
      cnt         <= cnt + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      channel_out <= ch;
      level_q8    <= quot;
      flat        <= flat_r;
    end
  end

  assign sts.skip_div = skip;
  assign sts.div_last = cnt == CNT_LAST;
  assign sts.out_busy = out_valid && out_stall;

endmodule

@@ rtl/core/minmax_sensor_normalizer.sv @@
// A result beat passes the mark update, scale, divide and finish states,
// then the output register; flat or out-of-range channels skip the divide.
// A new beat is taken only after the last result enters the output register;
// the restoring divider retires one quotient bit per cycle over 15 steps.
// Reset (rst, synchronous): controller idle, output empty, low marks all
// ones, high marks zero.
module minmax_sensor_normalizer #(
  parameter int CHANNELS    = mmsn_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = mmsn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mmsn_pkg::CH_W-1:0]     channel,
  input  logic [mmsn_pkg::SAMPLE_W-1:0] sample,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mmsn_pkg::CH_W-1:0]     channel_out,
  output logic [mmsn_pkg::LEVEL_W-1:0]  level_q8,
  output logic                          flat
);

  // Command and status between sequencer and datapath
  mmsn_pkg::cmd_t cmd;
  mmsn_pkg::sts_t sts;

  // Sequencer: idle -> mark update -> scale -> 15 divide steps (or none) -> finish.
  // Finish waits only while the output register holds an untaken beat.
  mmsn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: per-channel marks, x100 scaling, restoring divider and
  // the output register that decouples the result side.
  mmsn_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .channel     (channel),
    .sample      (sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel_out (channel_out),
    .level_q8    (level_q8),
    .flat        (flat)
  );

endmodule
